>>> rtl/s2lab_pkg.sv
`default_nettype none
package s2lab_pkg;

    localparam int QB            = 20;
    localparam int LIN_W         = QB + 1;
    localparam int SUM_W         = 44;
    localparam int UNIT_LAT      = LIN_W + 1;
    localparam int DIV_LAT       = 4;
    localparam int FRAC_BITS_DEF = 4;
    localparam int COEF_W        = 24;

    localparam logic [COEF_W-1:0] M_XR = 24'd4124564;
    localparam logic [COEF_W-1:0] M_XG = 24'd3575761;
    localparam logic [COEF_W-1:0] M_XB = 24'd1804375;
    localparam logic [COEF_W-1:0] M_YR = 24'd2126729;
    localparam logic [COEF_W-1:0] M_YG = 24'd7151522;
    localparam logic [COEF_W-1:0] M_YB = 24'd721750;
    localparam logic [COEF_W-1:0] M_ZR = 24'd193339;
    localparam logic [COEF_W-1:0] M_ZG = 24'd1191920;
    localparam logic [COEF_W-1:0] M_ZB = 24'd9503041;

    localparam longint unsigned DIV_X = 64'd9504700;
    localparam longint unsigned DIV_Y = 64'd10000000;
    localparam longint unsigned DIV_Z = 64'd10888300;
    localparam logic [SUM_W-1:0] RND_X = 44'd4752350;
    localparam logic [SUM_W-1:0] RND_Y = 44'd5000000;
    localparam logic [SUM_W-1:0] RND_Z = 44'd5444150;

    typedef enum logic {
        REG_DECODE   = 1'b0,
        REG_CHANNELS = 1'b1
    } t_reg_idx;

    function automatic longint unsigned lin_value(int v, bit srgb);
        longint unsigned vv, t, u, y, c, p;
        int b;
        vv = longint'(v);
        if (!srgb) begin
            return (vv * 64'd1048576 + 64'd127) / 64'd255;
        end
        if (vv <= 64'd10) begin
            return (vv * 64'd10 * 64'd1048576 + 64'd16473) / 64'd32946;
        end
        t = ((vv * 64'd1000 + 64'd14025) * 64'd1048576 + 64'd134512) / 64'd269025;
        u = (t * t + 64'd524288) >> QB;
        y = 64'd0;
        for (b = QB; b >= 0; b--) begin
            c = y | (64'd1 << b);
            p = (c * c) >> QB;
            p = (p * c) >> QB;
            p = (p * c) >> QB;
            p = (p * c) >> QB;
            if (p <= u) begin
                y = c;
            end
        end
        return (u * y + 64'd524288) >> QB;
    endfunction

    function automatic logic [256*LIN_W-1:0] lin_table(bit srgb);
        logic [256*LIN_W-1:0] tab;
        int i;
        tab = '0;
        for (i = 0; i < 256; i++) begin
            tab[i*LIN_W +: LIN_W] = LIN_W'(lin_value(i, srgb));
        end
        return tab;
    endfunction

    localparam logic [256*LIN_W-1:0] LIN_SRGB = lin_table(1'b1);
    localparam logic [256*LIN_W-1:0] LIN_RAW  = lin_table(1'b0);

endpackage
`default_nettype wire

>>> rtl/s2lab_cdiv.sv
`default_nettype none
module s2lab_cdiv
    import s2lab_pkg::*;
#(
    parameter int              NUM_W   = 44,
    parameter int              Q_W     = 21,
    parameter longint unsigned DIVISOR = 64'd1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    output logic      [Q_W-1:0]   o_quo
);
    // reciprocal estimate from the top numerator bits is low by at most one,
    // a remainder check adds the missing unit
    localparam int DROP = (NUM_W > 32) ? NUM_W - 32 : 0;
    localparam int TW   = NUM_W - DROP;
    localparam int RS   = 31 + $clog2(DIVISOR);
    localparam int DW   = $clog2(DIVISOR + 64'd1);
    localparam int PW   = Q_W + DW;
    localparam logic [31:0]      RECIP = 32'((64'd1 << RS) / DIVISOR);
    localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

    logic [TW-1:0]    r_top;
    logic [NUM_W-1:0] r_n0, r_n1, r_n2, r_qd, w_rem;
    logic [Q_W-1:0]   r_q1, r_q2, r_q3;
    logic [63:0]      w_prod;

    assign w_prod = 64'(r_top) * 64'(RECIP);
    assign w_rem  = r_n2 - r_qd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top <= i_num[NUM_W-1 -: TW];
            r_n0  <= i_num;
            r_q1  <= Q_W'(w_prod >> (RS - DROP));
            r_n1  <= r_n0;
            r_q2  <= r_q1;
            r_qd  <= NUM_W'(PW'(r_q1) * PW'(DIV_N));
            r_n2  <= r_n1;
            r_q3  <= r_q2 + Q_W'(w_rem >= DIV_N);
        end
    end

    assign o_quo = r_q3;
endmodule
`default_nettype wire

>>> rtl/s2lab_cbrt.sv
`default_nettype none
module s2lab_cbrt
    import s2lab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [LIN_W-1:0] i_t,
    output logic      [LIN_W-1:0] o_root
);
    // floor(cbrt(t * 2^40)), one root bit per stage
    localparam int NW  = 3 * LIN_W;
    localparam int RW  = 2 * LIN_W + 6;
    localparam int SQW = 2 * LIN_W;

    logic [LIN_W-1:0] r_in;
    logic [LIN_W-1:0] r_t   [LIN_W];
    logic [RW-1:0]    r_rem [LIN_W];
    logic [LIN_W-1:0] r_y   [LIN_W];
    logic [SQW-1:0]   r_sq  [LIN_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in <= i_t;
        end
    end

    for (genvar k = 0; k < LIN_W; k++) begin : g_stage
        localparam int GI = LIN_W - 1 - k;
        logic [LIN_W-1:0] w_t, w_y;
        logic [RW-1:0]    w_rem, w_remx, w_test;
        logic [SQW-1:0]   w_sq;
        logic [NW-1:0]    w_n;
        if (k == 0) begin : g_first
            assign w_t   = r_in;
            assign w_rem = '0;
            assign w_y   = '0;
            assign w_sq  = '0;
        end else begin : g_next
            assign w_t   = r_t[k-1];
            assign w_rem = r_rem[k-1];
            assign w_y   = r_y[k-1];
            assign w_sq  = r_sq[k-1];
        end
        assign w_n    = NW'(w_t) << (2 * QB);
        assign w_remx = (w_rem << 3) | RW'(w_n[3*GI +: 3]);
        assign w_test = (RW'(w_sq) << 3) + (RW'(w_sq) << 2)
                      + (RW'(w_y) << 2) + (RW'(w_y) << 1) + RW'(1);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k] <= w_t;
                if (w_remx >= w_test) begin
                    r_rem[k] <= w_remx - w_test;
                    r_y[k]   <= (w_y << 1) | LIN_W'(1);
                    r_sq[k]  <= (w_sq << 2) + (SQW'(w_y) << 2) + SQW'(1);
                end else begin
                    r_rem[k] <= w_remx;
                    r_y[k]   <= w_y << 1;
                    r_sq[k]  <= w_sq << 2;
                end
            end
        end
    end

    assign o_root = r_y[LIN_W-1];
endmodule
`default_nettype wire

>>> rtl/s2lab_labf.sv
`default_nettype none
module s2lab_labf
    import s2lab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [LIN_W-1:0] i_t,
    output logic      [LIN_W-1:0] o_f
);
    localparam int LN_W = LIN_W + 16;
    localparam int LT_W = 14;
    localparam int LD_W = LT_W + 16;
    localparam int LDLY = UNIT_LAT - DIV_LAT;

    logic [LN_W-1:0]    w_big_p;
    logic [LD_W-1:0]    w_num;
    logic               w_big;
    logic [UNIT_LAT-1:0] r_big;
    logic [LIN_W-1:0]   w_lin, w_root;
    logic [LIN_W-1:0]   r_lin [LDLY];

    // linear branch only serves t below 2^14
    assign w_num   = LD_W'(i_t[LT_W-1:0]) * LD_W'(24389)
                   + (LD_W'(432) << QB) + LD_W'(1566);
    assign w_big_p = LN_W'(i_t) * LN_W'(24389);
    assign w_big   = w_big_p > (LN_W'(216) << QB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big    <= {r_big[UNIT_LAT-2:0], w_big};
            r_lin[0] <= w_lin;
            for (int k = 1; k < LDLY; k++) begin
                r_lin[k] <= r_lin[k-1];
            end
        end
    end

    s2lab_cdiv #(.NUM_W(LD_W), .Q_W(LIN_W), .DIVISOR(64'd3132)) u_lin (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (w_num),
        .o_quo (w_lin)
    );

    s2lab_cbrt u_cbrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_t    (i_t),
        .o_root (w_root)
    );

    assign o_f = r_big[UNIT_LAT-1] ? w_root : r_lin[LDLY-1];
endmodule
`default_nettype wire

>>> rtl/srgb_to_cielab_pixel_core.sv
// sRGB pixel to CIE L*a*b* (D65) converter.
// Input stream: one word per pixel, tdata = red, green, blue, alpha bytes.
// Output stream: tdata = L* (11b), a* (12b), b* (12b) in 1/2^FRAC_BITS
// units, saturated; tuser = skipped flag (transparent pixel, outputs zero).
// APB port: reg 0 (addr 0) decode_srgb, reg 1 (addr 4) channel_count.
// Write config only while the pipeline is empty.
// Throughput: one pixel per clock while the receiver is not stalling. The
// pipeline depth is set mostly by the 4-stage reciprocal dividers for the XYZ
// normalization followed by the 22-stage cube root / linear branch.
// The pipeline advances as a whole whenever the output register is empty
// or being taken; when the receiver stalls every stage holds and
// s_axis tready drops, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and sets
// decode_srgb = 1, channel_count = 4.
`default_nettype none
module srgb_to_cielab_pixel_core
    import s2lab_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // red, green, blue, alpha
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,   // lightness, green_red, blue_yellow, pad
    output logic      [0:0]  o_m_axis_tuser,   // skipped
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready
);
    localparam int SH   = QB - FRAC_BITS;
    localparam int DL   = DIV_LAT + UNIT_LAT;
    localparam int PW   = SUM_W;

    logic       r_dec;
    logic [2:0] r_cc;
    logic       w_wr, w_en;
    t_reg_idx   w_idx;

    assign w_idx    = t_reg_idx'(i_paddr[2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec <= 1'b1;
            r_cc  <= 3'd4;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DECODE:   r_dec <= i_pwdata[0];
                REG_CHANNELS: r_cc  <= i_pwdata[2:0];
                default:      r_dec <= r_dec;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DECODE:   o_prdata = {31'd0, r_dec};
            REG_CHANNELS: o_prdata = {29'd0, r_cc};
            default:      o_prdata = '0;
        endcase
    end

    // stage A: channel fixup and alpha test
    logic       r_a_v, r_a_s;
    logic [7:0] r_a_r, r_a_g, r_a_b;
    logic [7:0] n_a_g, n_a_b;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        n_a_g = i_s_axis_tdata[15:8];
        n_a_b = i_s_axis_tdata[23:16];
        if (r_cc < 3'd2) begin
            n_a_g = i_s_axis_tdata[7:0];
        end
        if (r_cc < 3'd3) begin
            n_a_b = i_s_axis_tdata[7:0];
        end
    end

    // stage B: linearize, C: products, D: sums
    logic [LIN_W-1:0] r_b_lr, r_b_lg, r_b_lb;
    logic             r_b_v, r_b_s, r_c_v, r_c_s, r_d_v, r_d_s;
    logic [PW-1:0]    r_c_p [9];
    logic [PW-1:0]    r_d_x, r_d_y, r_d_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_s_axis_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_s <= r_cc[2] && (i_s_axis_tdata[31:24] < 8'd128);
            r_a_r <= i_s_axis_tdata[7:0];
            r_a_g <= n_a_g;
            r_a_b <= n_a_b;
            r_b_s <= r_a_s;
            if (r_dec) begin
                r_b_lr <= LIN_SRGB[r_a_r*LIN_W +: LIN_W];
                r_b_lg <= LIN_SRGB[r_a_g*LIN_W +: LIN_W];
                r_b_lb <= LIN_SRGB[r_a_b*LIN_W +: LIN_W];
            end else begin
                r_b_lr <= LIN_RAW[r_a_r*LIN_W +: LIN_W];
                r_b_lg <= LIN_RAW[r_a_g*LIN_W +: LIN_W];
                r_b_lb <= LIN_RAW[r_a_b*LIN_W +: LIN_W];
            end
            r_c_s    <= r_b_s;
            r_c_p[0] <= PW'(M_XR) * PW'(r_b_lr);
            r_c_p[1] <= PW'(M_XG) * PW'(r_b_lg);
            r_c_p[2] <= PW'(M_XB) * PW'(r_b_lb);
            r_c_p[3] <= PW'(M_YR) * PW'(r_b_lr);
            r_c_p[4] <= PW'(M_YG) * PW'(r_b_lg);
            r_c_p[5] <= PW'(M_YB) * PW'(r_b_lb);
            r_c_p[6] <= PW'(M_ZR) * PW'(r_b_lr);
            r_c_p[7] <= PW'(M_ZG) * PW'(r_b_lg);
            r_c_p[8] <= PW'(M_ZB) * PW'(r_b_lb);
            r_d_s    <= r_c_s;
            r_d_x    <= r_c_p[0] + r_c_p[1] + r_c_p[2] + RND_X;
            r_d_y    <= r_c_p[3] + r_c_p[4] + r_c_p[5] + RND_Y;
            r_d_z    <= r_c_p[6] + r_c_p[7] + r_c_p[8] + RND_Z;
        end
    end

    // white point normalization then Lab f()
    logic [LIN_W-1:0] w_tx, w_ty, w_tz, w_fx, w_fy, w_fz;

    s2lab_cdiv #(.NUM_W(PW), .Q_W(LIN_W), .DIVISOR(DIV_X)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_d_x), .o_quo(w_tx));
    s2lab_cdiv #(.NUM_W(PW), .Q_W(LIN_W), .DIVISOR(DIV_Y)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_d_y), .o_quo(w_ty));
    s2lab_cdiv #(.NUM_W(PW), .Q_W(LIN_W), .DIVISOR(DIV_Z)) u_div_z (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_d_z), .o_quo(w_tz));

    s2lab_labf u_f_x (.i_clk(i_clk), .i_en(w_en), .i_t(w_tx), .o_f(w_fx));
    s2lab_labf u_f_y (.i_clk(i_clk), .i_en(w_en), .i_t(w_ty), .o_f(w_fy));
    s2lab_labf u_f_z (.i_clk(i_clk), .i_en(w_en), .i_t(w_tz), .o_f(w_fz));

    logic [DL-1:0] r_dv, r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[DL-2:0], r_d_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds <= {r_ds[DL-2:0], r_d_s};
        end
    end

    // stage E: L, a, b formulas; F: round, clamp, output register
    logic signed [31:0] r_e_l, r_e_a, r_e_b;
    logic signed [31:0] w_sfx, w_sfy, w_sfz, w_rl, w_ra, w_rb;
    logic               r_e_v, r_e_s, r_f_v, r_f_s;
    logic [10:0]        r_f_l, n_f_l;
    logic [11:0]        r_f_a, r_f_b, n_f_a, n_f_b;

    assign w_sfx = signed'(32'(w_fx));
    assign w_sfy = signed'(32'(w_fy));
    assign w_sfz = signed'(32'(w_fz));
    assign w_rl  = (r_e_l + (32'sd1 <<< (SH - 1))) >>> SH;
    assign w_ra  = (r_e_a + (32'sd1 <<< (SH - 1))) >>> SH;
    assign w_rb  = (r_e_b + (32'sd1 <<< (SH - 1))) >>> SH;

    always_comb begin
        if (w_rl < 32'sd0) begin
            n_f_l = 11'd0;
        end else if (w_rl > 32'sd2047) begin
            n_f_l = 11'd2047;
        end else begin
            n_f_l = w_rl[10:0];
        end
        if (w_ra < -32'sd2048) begin
            n_f_a = 12'h800;
        end else if (w_ra > 32'sd2047) begin
            n_f_a = 12'h7FF;
        end else begin
            n_f_a = w_ra[11:0];
        end
        if (w_rb < -32'sd2048) begin
            n_f_b = 12'h800;
        end else if (w_rb > 32'sd2047) begin
            n_f_b = 12'h7FF;
        end else begin
            n_f_b = w_rb[11:0];
        end
        if (r_e_s) begin
            n_f_l = '0;
            n_f_a = '0;
            n_f_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_dv[DL-1];
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_s <= r_ds[DL-1];
            r_e_l <= 32'sd116 * w_sfy - (32'sd16 <<< QB);
            r_e_a <= 32'sd500 * (w_sfx - w_sfy);
            r_e_b <= 32'sd200 * (w_sfy - w_sfz);
            r_f_s <= r_e_s;
            r_f_l <= n_f_l;
            r_f_a <= n_f_a;
            r_f_b <= n_f_b;
        end
    end

    assign o_m_axis_tvalid = r_f_v;
    assign o_m_axis_tdata  = {5'd0, r_f_b, r_f_a, r_f_l};
    assign o_m_axis_tuser  = r_f_s;

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("skipped word carries nonzero color");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(r_dv) && $stable(r_e_v) && $stable(o_m_axis_tdata)))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
